@@ src/rpn_pkg.sv @@
`default_nettype none
package rpn_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

  localparam int KIND_W  = 2;
  localparam int VALUE_W = 32;
  localparam int OP_W    = 2;
  localparam int ERR_W   = 2;

  localparam logic [KIND_W-1:0] KIND_NUMBER   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OPERATOR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END      = 2'd2;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_MISSING  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_LEFTOVER = 2'd2;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd3;

  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [VALUE_W-1:0] word_t;
  typedef logic [OP_W-1:0]    opcode_t;
  typedef logic [ERR_W-1:0]   err_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic  has_value;
    word_t result_value;
    err_t  error_code;
  } result_t;

endpackage
`default_nettype wire

@@ src/rpn_if.sv @@
`default_nettype none
interface rpn_token_if;
  import rpn_pkg::*;
  logic         valid;
  logic         ready;
  kind_t        kind;
  logic signed [VALUE_W-1:0] token_value;
  opcode_t      operator_code;

  modport source (output valid, output kind, output token_value, output operator_code,
                  input ready);
  modport sink   (input valid, input kind, input token_value, input operator_code,
                  output ready);
endinterface

interface rpn_result_if;
  import rpn_pkg::*;
  logic         valid;
  logic         ready;
  logic         has_value;
  logic signed [VALUE_W-1:0] result_value;
  err_t         error_code;

  modport source (output valid, output has_value, output result_value, output error_code,
                  input ready);
  modport sink   (input valid, input has_value, input result_value, input error_code,
                  output ready);
endinterface
`default_nettype wire

@@ src/rpn_ram.sv @@
`default_nettype none
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                wdata,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/rpn_core.sv @@
`default_nettype none
module rpn_core (
  input  wire logic         clk,
  input  wire logic         rst,
  rpn_token_if.sink         tokens,
  input  wire logic         room,
  output logic              res_push,
  output rpn_pkg::result_t  res
);
  import rpn_pkg::*;

  count_t count, count_next;
  err_t   err_hold, err_hold_next;
  word_t  tos, tos_next;
  word_t  nos, nos_next;

  logic   fire;
  logic   we;
  addr_t  waddr, raddr;
  word_t  ram_rdata, below;
  logic   fwd_valid;
  word_t  fwd_data;
  word_t  alu;
  logic   op_known;

  assign tokens.ready = room;
  assign fire         = tokens.valid && room;
  assign op_known     = (tokens.operator_code == OP_ADD) || (tokens.operator_code == OP_SUB)
                        || (tokens.operator_code == OP_MUL);

  assign below = fwd_valid ? fwd_data : ram_rdata;

  always_comb begin
    case (tokens.operator_code)
      OP_ADD:  alu = nos + tos;
      OP_SUB:  alu = nos - tos;
      OP_MUL:  alu = nos * tos;
      default: alu = tos;
    endcase
  end

  always_comb begin
    count_next    = count;
    err_hold_next = err_hold;
    tos_next      = tos;
    nos_next      = nos;
    we            = 1'b0;
    waddr         = addr_t'(count - count_t'(2));
    res_push      = 1'b0;
    res.has_value    = 1'b0;
    res.result_value = '0;
    res.error_code   = ERR_NONE;
    if (fire) begin
      case (tokens.kind)
        KIND_NUMBER: begin
          if (err_hold == ERR_NONE) begin
            if (count == count_t'(STACK_DEPTH)) begin
              err_hold_next = ERR_OVERFLOW;
            end else begin
              tos_next   = word_t'(tokens.token_value);
              nos_next   = tos;
              we         = (count > count_t'(1));
              count_next = count + count_t'(1);
            end
          end
        end
        KIND_OPERATOR: begin
          if (err_hold == ERR_NONE && op_known) begin
            if (count < count_t'(2)) begin
              err_hold_next = ERR_MISSING;
            end else begin
              tos_next   = alu;
              nos_next   = below;
              count_next = count - count_t'(1);
            end
          end
        end
        KIND_END: begin
          res_push = 1'b1;
          if (err_hold != ERR_NONE) begin
            res.error_code = err_hold;
          end else if (count == count_t'(1)) begin
            res.has_value    = 1'b1;
            res.result_value = tos;
          end else if (count > count_t'(1)) begin
            res.error_code = ERR_LEFTOVER;
          end
          count_next    = '0;
          err_hold_next = ERR_NONE;
        end
        default: begin
        end
      endcase
    end
    raddr = addr_t'(count_next - count_t'(3));
  end

  rpn_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (nos),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      err_hold  <= ERR_NONE;
      fwd_valid <= 1'b0;
    end else begin
      count     <= count_next;
      err_hold  <= err_hold_next;
      fwd_valid <= we && (waddr == raddr);
    end
    tos      <= tos_next;
    nos      <= nos_next;
    fwd_data <= nos;
  end

endmodule
`default_nettype wire

@@ src/rpn_outq.sv @@
`default_nettype none
module rpn_outq (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         res_push,
  input  wire rpn_pkg::result_t res,
  output logic              room,
  rpn_result_if.source      results
);
  import rpn_pkg::*;

  logic    main_valid, skid_valid;
  result_t main_q, skid_q;
  logic    pop;

  assign room = !skid_valid;
  assign pop  = main_valid && results.ready;

  assign results.valid        = main_valid;
  assign results.has_value    = main_q.has_value;
  assign results.result_value = main_q.result_value;
  assign results.error_code   = main_q.error_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) begin
          main_valid <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (res_push) begin
        if (!main_valid || pop) begin
          main_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        main_valid <= 1'b0;
      end
    end
    if (skid_valid) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (res_push) begin
      if (!main_valid || pop) begin
        main_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/rpn_stack_evaluator.sv @@
// Postfix integer expression evaluator.
// tokens: one beat per token (number, operator or end of expression).
// results: one beat per end-of-expression token, carrying has_value,
//   result_value and error_code; number and operator tokens give no beat.
// Throughput: one token per cycle while tokens.ready is high. The two top
//   entries of the operand stack live in registers and the rest in a
//   one-port-write, one-port-read RAM whose read address is set from the
//   next stack count; a write-to-read bypass covers a push followed at once
//   by a pop.
// Output: each end token's result beat is registered in the output buffer.
// Reset (rst, synchronous) empties the stack, clears the held error and
//   drops any pending result beats; no clearing pass is needed.
// Stall: a two-beat output buffer holds results while the receiver stalls.
//   Tokens keep flowing until both beats are full; then tokens.ready drops
//   until a result beat is taken.
// Errors: missing operand, leftover operands or stack overflow; the first
//   error is held and later tokens are dropped until the end token.
`default_nettype none
module rpn_stack_evaluator (
  input  wire logic    clk,
  input  wire logic    rst,
  rpn_token_if.sink    tokens,
  rpn_result_if.source results
);
  import rpn_pkg::*;

  logic    room;
  logic    res_push;
  result_t res;

  rpn_core u_core (
    .clk      (clk),
    .rst      (rst),
    .tokens   (tokens),
    .room     (room),
    .res_push (res_push),
    .res      (res)
  );

  rpn_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .room     (room),
    .results  (results)
  );

endmodule
`default_nettype wire

@@ src/rpn_checker.sv @@
`default_nettype none
module rpn_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire rpn_pkg::kind_t       in_kind,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic                 out_has_value,
  input wire logic [rpn_pkg::VALUE_W-1:0] out_result_value,
  input wire rpn_pkg::err_t        out_error_code
);
  import rpn_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_has_value)
      && $stable(out_result_value) && $stable(out_error_code))
    else $error("result beat changed while stalled");

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_kind == KIND_END)))
    else $error("result beat without an end token");

  a_value_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_has_value |-> out_error_code == ERR_NONE)
    else $error("value reported together with an error");

  a_no_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_has_value |-> out_result_value == '0)
    else $error("nonzero result without a value");

endmodule

bind rpn_stack_evaluator rpn_checker u_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (tokens.valid),
  .in_ready         (tokens.ready),
  .in_kind          (tokens.kind),
  .out_valid        (results.valid),
  .out_ready        (results.ready),
  .out_has_value    (results.has_value),
  .out_result_value (results.result_value),
  .out_error_code   (results.error_code)
);
`default_nettype wire
